### rtl/core/quaternion_to_euler_angles_top_macros.svh
// assertion helpers for the port checker of this block
// each macro expects clk and rst_n in the scope where it is used
`ifndef QUATERNION_TO_EULER_ANGLES_TOP_MACROS_SVH
`define QUATERNION_TO_EULER_ANGLES_TOP_MACROS_SVH

// same-cycle implication
`define Q2E_ASSERT_IMPL(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define Q2E_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/core/q2e_pkg.sv
// ----------------------------------------------------------------------------
// q2e_pkg
// shared widths, payload types and angle table of the quaternion to euler block
// ----------------------------------------------------------------------------
`default_nettype none

package q2e_pkg;

    localparam int CW                = 40;   // cordic x/y datapath
    localparam int ZW                = 28;   // angle accumulator, 2^-24 rad
    localparam int QW                = 18;   // rounded q3.13 before saturation
    localparam int SQ_STEPS          = 29;   // result bits of the square root
    localparam int ATAN_LEN          = 24;
    localparam int CORDIC_STAGES_DEF = 16;

    localparam logic signed [ZW-1:0] HALF_PI_U24 = 28'sd26353589;
    localparam logic signed [QW-1:0] PI_Q13      = 18'sd25736;
    localparam logic signed [QW-1:0] HALF_PI_Q13 = 18'sd12868;
    localparam logic [14:0]          LIMIT_RESET = 15'd16383;

    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [ZW-1:0] z;
        logic                 zero;
    } lane_t;

    typedef struct packed {
        lane_t              roll;
        lane_t              yaw;
        logic signed [29:0] ys;
        logic [56:0]        rem;
        logic [57:0]        res;
        logic               cpos;
        logic               cneg;
    } sq_t;

    typedef struct packed {
        lane_t roll;
        lane_t pitch;
        lane_t yaw;
        logic  cpos;
        logic  cneg;
    } cord_t;

    function automatic logic signed [ZW-1:0] atan_u24(input int idx);
        case (idx)
            0:       return 28'sd13176795;
            1:       return 28'sd7778716;
            2:       return 28'sd4110060;
            3:       return 28'sd2086331;
            4:       return 28'sd1047214;
            5:       return 28'sd524117;
            6:       return 28'sd262123;
            7:       return 28'sd131069;
            8:       return 28'sd65536;
            9:       return 28'sd32768;
            10:      return 28'sd16384;
            11:      return 28'sd8192;
            12:      return 28'sd4096;
            13:      return 28'sd2048;
            14:      return 28'sd1024;
            15:      return 28'sd512;
            16:      return 28'sd256;
            17:      return 28'sd128;
            18:      return 28'sd64;
            19:      return 28'sd32;
            20:      return 28'sd16;
            21:      return 28'sd8;
            22:      return 28'sd4;
            23:      return 28'sd2;
            default: return 28'sd0;
        endcase
    endfunction

    // round half up to q3.13, then clamp to +/-lim
    function automatic logic signed [QW-1:0] to_q13(input logic signed [ZW-1:0] z,
                                                    input logic signed [QW-1:0] lim);
        logic signed [ZW:0]   s;
        logic signed [QW-1:0] r;
        s = {z[ZW-1], z} + (ZW+1)'(1024);
        r = QW'(s >>> 11);
        if (r > lim)
        begin
            r = lim;
        end
        if (r < -lim)
        begin
            r = -lim;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

### rtl/core/q2e_quat_if.sv
// ----------------------------------------------------------------------------
// q2e_quat_if
// quaternion input channel, valid/ready
// ----------------------------------------------------------------------------
`default_nettype none

interface q2e_quat_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] quat_x;
    logic signed [15:0] quat_y;
    logic signed [15:0] quat_z;
    logic signed [15:0] quat_w;

    modport source (output valid, quat_x, quat_y, quat_z, quat_w, input ready);
    modport sink   (input valid, quat_x, quat_y, quat_z, quat_w, output ready);
endinterface

`default_nettype wire

### rtl/core/q2e_euler_if.sv
// ----------------------------------------------------------------------------
// q2e_euler_if
// euler angle result channel, valid/ready
// ----------------------------------------------------------------------------
`default_nettype none

interface q2e_euler_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] roll_angle;
    logic signed [14:0] pitch_angle;
    logic signed [15:0] yaw_angle;

    modport source (output valid, roll_angle, pitch_angle, yaw_angle, input ready);
    modport sink   (input valid, roll_angle, pitch_angle, yaw_angle, output ready);
endinterface

`default_nettype wire

### rtl/core/q2e_front.sv
// ----------------------------------------------------------------------------
// q2e_front
// products, sums, quadrant prep, singularity test and 1 - s^2 in four stages
// ----------------------------------------------------------------------------
`default_nettype none

module q2e_front (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic [14:0]        limit,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic signed [15:0] quat_x,
    input  wire logic signed [15:0] quat_y,
    input  wire logic signed [15:0] quat_z,
    input  wire logic signed [15:0] quat_w,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output q2e_pkg::sq_t            out_data
);

    typedef struct packed {
        logic signed [31:0] xx, yy, zz, ww, wy, xz, xy, wz, yz, wx;
    } prod_t;

    typedef struct packed {
        logic signed [33:0] sp, yaw_y, yaw_x, roll_y, roll_x;
    } sum_t;

    typedef struct packed {
        q2e_pkg::lane_t     roll;
        q2e_pkg::lane_t     yaw;
        logic signed [29:0] ys;
        logic               cpos;
        logic               cneg;
    } prep_t;

    // fold the left half plane onto the right one
    function automatic q2e_pkg::lane_t prep(input logic signed [33:0] y,
                                            input logic signed [33:0] x);
        q2e_pkg::lane_t             l;
        logic signed [q2e_pkg::CW-1:0] xe;
        logic signed [q2e_pkg::CW-1:0] ye;
        xe     = q2e_pkg::CW'(x);
        ye     = q2e_pkg::CW'(y);
        l.zero = (x == '0) && (y == '0);
        if (x < 0)
        begin
            if (y >= 0)
            begin
                l.x = ye;
                l.y = -xe;
                l.z = q2e_pkg::HALF_PI_U24;
            end
            else
            begin
                l.x = -ye;
                l.y = xe;
                l.z = -q2e_pkg::HALF_PI_U24;
            end
        end
        else
        begin
            l.x = xe;
            l.y = ye;
            l.z = '0;
        end
        return l;
    endfunction

    logic  s1_v_reg, s2_v_reg, s3_v_reg, s4_v_reg;
    logic  s1_rdy, s2_rdy, s3_rdy, s4_rdy;
    prod_t s1_reg, s1_next;
    sum_t  s2_reg, s2_next;
    prep_t s3_reg, s3_next;
    q2e_pkg::sq_t s4_reg, s4_next;

    assign s4_rdy   = !s4_v_reg || out_ready;
    assign s3_rdy   = !s3_v_reg || s4_rdy;
    assign s2_rdy   = !s2_v_reg || s3_rdy;
    assign s1_rdy   = !s1_v_reg || s2_rdy;
    assign in_ready = s1_rdy;

    // stage 1: component products, exact in q4.28
    always_comb
    begin
        s1_next.xx = 32'(quat_x * quat_x);
        s1_next.yy = 32'(quat_y * quat_y);
        s1_next.zz = 32'(quat_z * quat_z);
        s1_next.ww = 32'(quat_w * quat_w);
        s1_next.wy = 32'(quat_w * quat_y);
        s1_next.xz = 32'(quat_x * quat_z);
        s1_next.xy = 32'(quat_x * quat_y);
        s1_next.wz = 32'(quat_w * quat_z);
        s1_next.yz = 32'(quat_y * quat_z);
        s1_next.wx = 32'(quat_w * quat_x);
    end

    // stage 2: atan2 and asin arguments
    always_comb
    begin
        logic signed [32:0] d_sp, d_yaw, d_roll;
        d_sp           = 33'(s1_reg.wy) - 33'(s1_reg.xz);
        d_yaw          = 33'(s1_reg.xy) + 33'(s1_reg.wz);
        d_roll         = 33'(s1_reg.yz) + 33'(s1_reg.wx);
        s2_next.sp     = {d_sp, 1'b0};
        s2_next.yaw_y  = {d_yaw, 1'b0};
        s2_next.roll_y = {d_roll, 1'b0};
        s2_next.yaw_x  = 34'(s1_reg.ww) + 34'(s1_reg.xx) - 34'(s1_reg.yy) - 34'(s1_reg.zz);
        s2_next.roll_x = 34'(s1_reg.ww) - 34'(s1_reg.xx) - 34'(s1_reg.yy) + 34'(s1_reg.zz);
    end

    // stage 3: singularity test, asin argument saturation, quadrant prep
    always_comb
    begin
        logic signed [34:0] sr;
        logic signed [20:0] s14;
        logic signed [20:0] lim;
        sr            = 35'(s2_reg.sp) + 35'sd8192;
        s14           = 21'(sr >>> 14);
        lim           = $signed({6'b0, limit});
        s3_next.cpos  = s14 > lim;
        s3_next.cneg  = s14 < -lim;
        if (s2_reg.sp > 34'sd268435456)
        begin
            s3_next.ys = 30'sd268435456;
        end
        else if (s2_reg.sp < -34'sd268435456)
        begin
            s3_next.ys = -30'sd268435456;
        end
        else
        begin
            s3_next.ys = 30'(s2_reg.sp);
        end
        s3_next.roll = prep(s2_reg.roll_y, s2_reg.roll_x);
        s3_next.yaw  = prep(s2_reg.yaw_y, s2_reg.yaw_x);
    end

    // stage 4: 1 - s^2 in q56 for the square root
    always_comb
    begin
        logic [28:0] ysabs;
        logic [57:0] ysq;
        ysabs        = s3_reg.ys[29] ? 29'(-s3_reg.ys) : 29'(s3_reg.ys);
        ysq          = 58'(ysabs) * 58'(ysabs);
        s4_next.roll = s3_reg.roll;
        s4_next.yaw  = s3_reg.yaw;
        s4_next.ys   = s3_reg.ys;
        s4_next.cpos = s3_reg.cpos;
        s4_next.cneg = s3_reg.cneg;
        s4_next.rem  = 57'((58'd1 << 56) - ysq);
        s4_next.res  = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg <= 1'b0;
            s2_v_reg <= 1'b0;
            s3_v_reg <= 1'b0;
            s4_v_reg <= 1'b0;
        end
        else
        begin
            if (s1_rdy)
            begin
                s1_v_reg <= in_valid;
            end
            if (s2_rdy)
            begin
                s2_v_reg <= s1_v_reg;
            end
            if (s3_rdy)
            begin
                s3_v_reg <= s2_v_reg;
            end
            if (s4_rdy)
            begin
                s4_v_reg <= s3_v_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_rdy && in_valid)
        begin
            s1_reg <= s1_next;
        end
        if (s2_rdy && s1_v_reg)
        begin
            s2_reg <= s2_next;
        end
        if (s3_rdy && s2_v_reg)
        begin
            s3_reg <= s3_next;
        end
        if (s4_rdy && s3_v_reg)
        begin
            s4_reg <= s4_next;
        end
    end

    assign out_valid = s4_v_reg;
    assign out_data  = s4_reg;

endmodule

`default_nettype wire

### rtl/core/q2e_sqrt_cell.sv
// ----------------------------------------------------------------------------
// q2e_sqrt_cell
// one result bit of the integer square root, digit-by-digit
// ----------------------------------------------------------------------------
`default_nettype none

module q2e_sqrt_cell #(
    parameter int K = 0
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         in_valid,
    output logic              in_ready,
    input  wire q2e_pkg::sq_t in_data,
    output logic              out_valid,
    input  wire logic         out_ready,
    output q2e_pkg::sq_t      out_data
);

    localparam int          SH   = 2 * (q2e_pkg::SQ_STEPS - 1 - K);
    localparam logic [57:0] BITV = 58'd1 << SH;

    logic         v_reg;
    q2e_pkg::sq_t d_reg, d_next;

    assign in_ready = !v_reg || out_ready;

    always_comb
    begin
        logic [57:0] t;
        t      = in_data.res + BITV;
        d_next = in_data;
        if ({1'b0, in_data.rem} >= t)
        begin
            d_next.rem = in_data.rem - t[56:0];
            d_next.res = (in_data.res >> 1) + BITV;
        end
        else
        begin
            d_next.res = in_data.res >> 1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            v_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            d_reg <= d_next;
        end
    end

    assign out_valid = v_reg;
    assign out_data  = d_reg;

endmodule

`default_nettype wire

### rtl/core/q2e_cordic_cell.sv
// ----------------------------------------------------------------------------
// q2e_cordic_cell
// one vectoring micro-rotation for the roll, pitch and yaw lanes
// ----------------------------------------------------------------------------
`default_nettype none

module q2e_cordic_cell #(
    parameter int I = 0
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    output logic                in_ready,
    input  wire q2e_pkg::cord_t in_data,
    output logic                out_valid,
    input  wire logic           out_ready,
    output q2e_pkg::cord_t      out_data
);

    localparam logic signed [q2e_pkg::ZW-1:0] ANG = q2e_pkg::atan_u24(I);

    function automatic q2e_pkg::lane_t rot(input q2e_pkg::lane_t l);
        q2e_pkg::lane_t                r;
        logic signed [q2e_pkg::CW-1:0] xs;
        logic signed [q2e_pkg::CW-1:0] ys;
        xs     = l.x >>> I;
        ys     = l.y >>> I;
        r.zero = l.zero;
        if (l.y > 0)
        begin
            r.x = l.x + ys;
            r.y = l.y - xs;
            r.z = l.z + ANG;
        end
        else
        begin
            r.x = l.x - ys;
            r.y = l.y + xs;
            r.z = l.z - ANG;
        end
        return r;
    endfunction

    logic           v_reg;
    q2e_pkg::cord_t d_reg, d_next;

    assign in_ready = !v_reg || out_ready;

    always_comb
    begin
        d_next       = in_data;
        d_next.roll  = rot(in_data.roll);
        d_next.pitch = rot(in_data.pitch);
        d_next.yaw   = rot(in_data.yaw);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            v_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            d_reg <= d_next;
        end
    end

    assign out_valid = v_reg;
    assign out_data  = d_reg;

endmodule

`default_nettype wire

### rtl/core/quaternion_to_euler_angles_top.sv
// throughput: one item per cycle while the output is not stalled; every stage is a register with its own valid
// ready ripples back stage by stage, so bubbles close up under output stalls
// the square root chain (29 cells) and the cordic chain make up most of the pipeline
// reset: async active low, empties the pipeline and loads singularity_limit = 16383
// ----------------------------------------------------------------------------
// quaternion_to_euler_angles_top
// unit quaternion in q2.14 to zyx euler angles in q3.13 radians
// ----------------------------------------------------------------------------
`default_nettype none

module quaternion_to_euler_angles_top #(
    parameter int CORDIC_STAGES = q2e_pkg::CORDIC_STAGES_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [14:0] cfg_wdata,
    q2e_quat_if.sink         quat,
    q2e_euler_if.source      euler
);

    localparam int SQ = q2e_pkg::SQ_STEPS;

    // singularity limit register
    logic [14:0] limit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= q2e_pkg::LIMIT_RESET;
        end
        else if (cfg_we)
        begin
            limit_reg <= cfg_wdata;
        end
    end

    // front end: products, sums, prep, 1 - s^2
    logic         sq_v [SQ+1];
    logic         sq_r [SQ+1];
    q2e_pkg::sq_t sq_d [SQ+1];

    q2e_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .limit     (limit_reg),
        .in_valid  (quat.valid),
        .in_ready  (quat.ready),
        .quat_x    (quat.quat_x),
        .quat_y    (quat.quat_y),
        .quat_z    (quat.quat_z),
        .quat_w    (quat.quat_w),
        .out_valid (sq_v[0]),
        .out_ready (sq_r[0]),
        .out_data  (sq_d[0])
    );

    // square root chain: one result bit per cell, roll and yaw lanes ride along
    for (genvar k = 0; k < SQ; k++)
    begin : g_sqrt
        q2e_sqrt_cell #(
            .K (k)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (sq_v[k]),
            .in_ready  (sq_r[k]),
            .in_data   (sq_d[k]),
            .out_valid (sq_v[k+1]),
            .out_ready (sq_r[k+1]),
            .out_data  (sq_d[k+1])
        );
    end

    // cordic chain
    logic           cd_v [CORDIC_STAGES+1];
    logic           cd_r [CORDIC_STAGES+1];
    q2e_pkg::cord_t cd_d [CORDIC_STAGES+1];

    // asin(s) as atan2(s, sqrt(1 - s^2)); cosine side is never negative
    always_comb
    begin
        cd_d[0].roll       = sq_d[SQ].roll;
        cd_d[0].yaw        = sq_d[SQ].yaw;
        cd_d[0].pitch.x    = q2e_pkg::CW'($signed({1'b0, sq_d[SQ].res[28:0]}));
        cd_d[0].pitch.y    = q2e_pkg::CW'(sq_d[SQ].ys);
        cd_d[0].pitch.z    = '0;
        cd_d[0].pitch.zero = 1'b0;
        cd_d[0].cpos       = sq_d[SQ].cpos;
        cd_d[0].cneg       = sq_d[SQ].cneg;
    end

    assign cd_v[0]  = sq_v[SQ];
    assign sq_r[SQ] = cd_r[0];

    for (genvar i = 0; i < CORDIC_STAGES; i++)
    begin : g_cordic
        q2e_cordic_cell #(
            .I (i)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (cd_v[i]),
            .in_ready  (cd_r[i]),
            .in_data   (cd_d[i]),
            .out_valid (cd_v[i+1]),
            .out_ready (cd_r[i+1]),
            .out_data  (cd_d[i+1])
        );
    end

    // output register: round to q3.13, saturate, clamp pitch at the singularity
    logic               out_v_reg;
    logic signed [15:0] roll_reg, roll_next;
    logic signed [14:0] pitch_reg, pitch_next;
    logic signed [15:0] yaw_reg, yaw_next;
    q2e_pkg::cord_t     fin;

    assign fin                 = cd_d[CORDIC_STAGES];
    assign cd_r[CORDIC_STAGES] = !out_v_reg || euler.ready;

    always_comb
    begin
        // both atan2 arguments zero gives angle zero
        roll_next = fin.roll.zero ? '0 :
                    16'(q2e_pkg::to_q13(fin.roll.z, q2e_pkg::PI_Q13));
        yaw_next  = fin.yaw.zero ? '0 :
                    16'(q2e_pkg::to_q13(fin.yaw.z, q2e_pkg::PI_Q13));
        if (fin.cpos)
        begin
            pitch_next = 15'(q2e_pkg::HALF_PI_Q13);
        end
        else if (fin.cneg)
        begin
            pitch_next = 15'(-q2e_pkg::HALF_PI_Q13);
        end
        else
        begin
            pitch_next = 15'(q2e_pkg::to_q13(fin.pitch.z, q2e_pkg::HALF_PI_Q13));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_v_reg <= 1'b0;
        end
        else if (cd_r[CORDIC_STAGES])
        begin
            out_v_reg <= cd_v[CORDIC_STAGES];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cd_r[CORDIC_STAGES] && cd_v[CORDIC_STAGES])
        begin
            roll_reg  <= roll_next;
            pitch_reg <= pitch_next;
            yaw_reg   <= yaw_next;
        end
    end

    assign euler.valid       = out_v_reg;
    assign euler.roll_angle  = roll_reg;
    assign euler.pitch_angle = pitch_reg;
    assign euler.yaw_angle   = yaw_reg;

endmodule

`default_nettype wire

### rtl/core/q2e_checker.sv
// ----------------------------------------------------------------------------
// q2e_checker
// port-level checks of the quaternion to euler block, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

`include "quaternion_to_euler_angles_top_macros.svh"

module q2e_port_checker (
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               in_ready,
    input wire logic               out_valid,
    input wire logic               out_ready,
    input wire logic signed [15:0] roll_angle,
    input wire logic signed [14:0] pitch_angle,
    input wire logic signed [15:0] yaw_angle
);

    // a stalled result item stays offered
    `Q2E_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result item dropped")

    // with nothing offered the output stage is free, so input must be open
    `Q2E_ASSERT_IMPL(a_in_open, !out_valid, in_ready, "input blocked with empty output")

    `Q2E_ASSERT_IMPL(a_pitch_rng, out_valid,
        (pitch_angle <= 15'sd12868) && (pitch_angle >= -15'sd12868), "pitch out of range")

    `Q2E_ASSERT_IMPL(a_ry_rng, out_valid,
        (roll_angle <= 16'sd25736) && (roll_angle >= -16'sd25736) &&
        (yaw_angle <= 16'sd25736) && (yaw_angle >= -16'sd25736), "roll or yaw out of range")

endmodule

bind quaternion_to_euler_angles_top q2e_port_checker u_q2e_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ready    (quat.ready),
    .out_valid   (euler.valid),
    .out_ready   (euler.ready),
    .roll_angle  (euler.roll_angle),
    .pitch_angle (euler.pitch_angle),
    .yaw_angle   (euler.yaw_angle)
);

`default_nettype wire

### verif/q2e_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// q2e_checker
// watches the quaternion and euler channels, predicts the three angles of
// every accepted quaternion and compares them in order with the block
// ----------------------------------------------------------------------------
`default_nettype none

module q2e_checker #(
    parameter int CORDIC_STAGES = q2e_pkg::CORDIC_STAGES_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [14:0] cfg_wdata,
    q2e_quat_if              quat,
    q2e_euler_if             euler,
    output int               fail_count,
    output int               pending_angles
);

    typedef struct packed {
        logic signed [15:0] roll;
        logic signed [14:0] pitch;
        logic signed [15:0] yaw;
    } angles_t;

    localparam longint HALF_PI_RAD24 = 64'sd26353589;
    localparam longint ONE_Q28       = 64'sd268435456;

    angles_t     angle_queue[$];
    logic [14:0] clamp_limit;

    function automatic longint stage_angle(input int i);
        longint tbl[24] = '{13176795, 7778716, 4110060, 2086331, 1047214, 524117,
                            262123, 131069, 65536, 32768, 16384, 8192, 4096, 2048,
                            1024, 512, 256, 128, 64, 32, 16, 8, 4, 2};
        return tbl[i];
    endfunction

    function automatic longint int_sqrt(input longint unsigned v);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v)
            b >>= 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v -= r + b;
                r = (r >> 1) + b;
            end
            else
                r >>= 1;
            b >>= 2;
        end
        return longint'(r);
    endfunction

    // vectoring cordic, angle in 2^-24 rad
    function automatic longint vec_atan2(input longint y, input longint x);
        longint z, t, xs, ys;
        z = 0;
        if (x == 0 && y == 0)
            return 0;
        if (x < 0)
        begin
            t = x;
            if (y >= 0)
            begin
                x = y;
                y = -t;
                z = HALF_PI_RAD24;
            end
            else
            begin
                x = -y;
                y = t;
                z = -HALF_PI_RAD24;
            end
        end
        for (int i = 0; i < CORDIC_STAGES && i < 24; i++)
        begin
            xs = x >>> i;
            ys = y >>> i;
            if (y > 0)
            begin
                x += ys;
                y -= xs;
                z += stage_angle(i);
            end
            else
            begin
                x -= ys;
                y += xs;
                z -= stage_angle(i);
            end
        end
        return z;
    endfunction

    function automatic longint round_q13(input longint a, input longint lim);
        longint r;
        r = (a + 1024) >>> 11;
        if (r > lim)
            r = lim;
        if (r < -lim)
            r = -lim;
        return r;
    endfunction

    function automatic angles_t euler_of(input logic signed [15:0] qx,
                                         input logic signed [15:0] qy,
                                         input logic signed [15:0] qz,
                                         input logic signed [15:0] qw,
                                         input logic [14:0] lim);
        longint x, y, z, w, s28, s14, ys, c, p;
        angles_t a;
        x = qx;
        y = qy;
        z = qz;
        w = qw;
        s28 = 2 * (w * y - x * z);
        s14 = (s28 + 8192) >>> 14;
        if (s14 > longint'(lim))
            p = 12868;
        else if (s14 < -longint'(lim))
            p = -12868;
        else
        begin
            ys = s28;
            if (ys > ONE_Q28)
                ys = ONE_Q28;
            if (ys < -ONE_Q28)
                ys = -ONE_Q28;
            c = int_sqrt(longint'(64'd1 << 56) - ys * ys);
            p = round_q13(vec_atan2(ys, c), 12868);
        end
        a.pitch = 15'(p);
        a.yaw   = 16'(round_q13(vec_atan2(2 * (x * y + w * z), w*w + x*x - y*y - z*z), 25736));
        a.roll  = 16'(round_q13(vec_atan2(2 * (y * z + w * x), w*w - x*x - y*y + z*z), 25736));
        return a;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        angles_t want;
        if (!rst_n)
        begin
            clamp_limit = q2e_pkg::LIMIT_RESET;
            fail_count  = 0;
            angle_queue.delete();
            pending_angles = 0;
        end
        else
        begin
            if (quat.valid && quat.ready)
                angle_queue.push_back(euler_of(quat.quat_x, quat.quat_y, quat.quat_z,
                                               quat.quat_w, clamp_limit));
            if (cfg_we)
                clamp_limit = cfg_wdata;
            if (euler.valid && euler.ready)
            begin
                if (angle_queue.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected item: roll %0d pitch %0d yaw %0d",
                                 euler.roll_angle, euler.pitch_angle, euler.yaw_angle);
                end
                else
                begin
                    want = angle_queue.pop_front();
                    if (want.roll !== euler.roll_angle || want.pitch !== euler.pitch_angle
                        || want.yaw !== euler.yaw_angle)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("mismatch: want r %0d p %0d y %0d, got r %0d p %0d y %0d",
                                     want.roll, want.pitch, want.yaw, euler.roll_angle,
                                     euler.pitch_angle, euler.yaw_angle);
                    end
                end
            end
            pending_angles = angle_queue.size();
        end
    end

endmodule

`default_nettype wire

### verif/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// drives quaternions into the euler block under changing limits and
// handshake pressure; the checker predicts and compares every angle item
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [14:0] cfg_wdata;
    int          fail_count;
    int          pending_angles;
    int          send_idle_pct;   // chance per cycle the sender holds off
    int          recv_stall_pct;  // chance per cycle the receiver stalls

    q2e_quat_if  quat ();
    q2e_euler_if euler ();

    quaternion_to_euler_angles_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .quat      (quat),
        .euler     (euler)
    );

    q2e_checker chk (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata),
        .quat           (quat),
        .euler          (euler),
        .fail_count     (fail_count),
        .pending_angles (pending_angles)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // receiver side: random stalls at the configured rate
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            euler.ready <= 1'b0;
        else
            euler.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // pick a component value: mostly in range, sometimes any 16-bit pattern
    function automatic logic signed [15:0] pick_comp();
        case ($urandom_range(9))
            0:       return 16'($urandom);
            1:       return $urandom_range(1) ? 16'sd16384 : -16'sd16384;
            default: return 16'($signed($urandom_range(32768)) - 16384);
        endcase
    endfunction

    // send one item, holding valid until it is taken
    task automatic send_quat(input logic signed [15:0] x, input logic signed [15:0] y,
                             input logic signed [15:0] z, input logic signed [15:0] w);
        while ($urandom_range(99) < send_idle_pct)
        begin
            quat.valid <= 1'b0;
            @(posedge clk);
        end
        quat.valid  <= 1'b1;
        quat.quat_x <= x;
        quat.quat_y <= y;
        quat.quat_z <= z;
        quat.quat_w <= w;
        @(posedge clk);
        while (!quat.ready)
            @(posedge clk);
    endtask

    // random quaternion: components picked freely, near the pitch singularity, or w large and the rest spread
    task automatic send_random();
        int k;
        if ($urandom_range(3) == 0)
            send_quat(pick_comp(), pick_comp(), pick_comp(), pick_comp());
        else
        begin
            // near the pitch singularity (w = y, x = -z), or else w large and the rest spread
            k = $urandom_range(11585 - 300, 11585 + 300);
            if ($urandom_range(1))
                send_quat(16'(k), 16'(k), -16'(k), 16'(k));
            else
                send_quat(pick_comp(), pick_comp() >>> 1, pick_comp() >>> 2,
                          16'($urandom_range(16384, 8000)));
        end
    endtask

    // drain, let the pipeline settle, then write the limit
    task automatic write_limit(input logic [14:0] v);
        quat.valid <= 1'b0;
        @(posedge clk);
        while (pending_angles != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    initial
    begin
        logic [14:0] limits[5] = '{15'd16383, 15'd0, 15'd16384, 15'd32767, 15'd15000};
        cfg_we         = 1'b0;
        cfg_wdata      = '0;
        quat.valid     = 1'b0;
        quat.quat_x    = '0;
        quat.quat_y    = '0;
        quat.quat_z    = '0;
        quat.quat_w    = '0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        rst_n          = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: identity, axes, extremes, zero, singularity both signs
        send_quat(16'sd0, 16'sd0, 16'sd0, 16'sd16384);
        send_quat(16'sd16384, 16'sd0, 16'sd0, 16'sd0);
        send_quat(16'sd0, 16'sd16384, 16'sd0, 16'sd0);
        send_quat(16'sd0, 16'sd0, 16'sd16384, 16'sd0);
        send_quat(16'sd0, 16'sd0, 16'sd0, -16'sd16384);
        send_quat(16'sd0, 16'sd0, 16'sd0, 16'sd0);
        send_quat(16'sd11585, 16'sd11585, -16'sd11585, 16'sd11585);
        send_quat(-16'sd11585, -16'sd11585, -16'sd11585, 16'sd11585);
        send_quat(16'sd0, 16'sd11585, 16'sd0, 16'sd11585);
        send_quat(16'sd0, -16'sd11585, 16'sd0, 16'sd11585);
        send_quat(-16'sd16384, -16'sd16384, -16'sd16384, -16'sd16384);
        send_quat(16'sd16384, 16'sd16384, 16'sd16384, 16'sd16384);
        send_quat(16'h7fff, 16'h8000, 16'h7fff, 16'h8000);
        send_quat(-16'sd1, -16'sd1, -16'sd1, -16'sd1);
        send_quat(16'sd0, 16'sd8192, 16'sd0, -16'sd16384);
        send_quat(16'sd100, -16'sd200, 16'sd300, 16'sd16000);

        // random phases over limit settings and idling mixes
        for (int ph = 0; ph < 10; ph++)
        begin
            write_limit(limits[ph % 5]);
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 85; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 85; end
                default: begin send_idle_pct = 11; recv_stall_pct = 11; end
            endcase
            for (int n = 0; n < 125; n++)
                send_random();
        end
        quat.valid <= 1'b0;
        @(posedge clk);
        while (pending_angles != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);

        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("FAILURE");
        $finish;
    end

endmodule

`default_nettype wire
